FILE: rtl/lhc_pkg.sv
// Package for the LRU handle cache: opcodes, status codes, result kinds and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package lhc_pkg;

	localparam int CAP_W  = 5;
	localparam int ADDR_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;
	localparam logic [0:0]       REG_CAPACITY = 1'b0;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_TRIM   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;
	localparam logic [1:0] ST_RELEASE = 2'd3;

	// Kinds of result beat the controller can ask the datapath to load.
	localparam logic [2:0] EM_MISS   = 3'd0;
	localparam logic [2:0] EM_REJECT = 3'd1;
	localparam logic [2:0] EM_HIT    = 3'd2;
	localparam logic [2:0] EM_REL    = 3'd3;
	localparam logic [2:0] EM_INSERT = 3'd4;
	localparam logic [2:0] EM_DONE   = 3'd5;

	typedef struct packed {
		logic       latch;
		logic       scan;
		logic       remove;
		logic       touch;
		logic       insert;
		logic       read;
		logic       emit;
		logic [2:0] kind;
		logic       pend;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       handle_zero;
		logic       go;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/lhc_ctrl.sv
// Controller state machine of the LRU handle cache: sequences scan and action
// steps and orders the result beats. Depends on lhc_pkg.
`default_nettype none

module lhc_ctrl import lhc_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_ACT  = 2'd2;
	localparam logic [1:0] S_HIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       pend_q;
	logic       pend_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.pend = pend_q;
		state_d  = state_q;
		pend_d   = pend_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					pend_d    = 1'b0;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = S_ACT;
			end
			S_ACT: begin
				// Nothing is done until the output register can take a beat.
				if (sts.out_free) begin
					case (sts.op)
						OP_LOOKUP: begin
							if (sts.go) begin
								cmd.touch = 1'b1;
								cmd.read  = 1'b1;
								state_d   = S_HIT;
							end else begin
								cmd.emit = 1'b1;
								cmd.kind = EM_MISS;
								state_d  = S_IDLE;
							end
						end
						OP_INSERT: begin
							if (sts.handle_zero) begin
								cmd.emit = 1'b1;
								cmd.kind = EM_REJECT;
								state_d  = S_IDLE;
							end else if (sts.go) begin
								cmd.remove = 1'b1;
								cmd.read   = 1'b1;
								cmd.emit   = pend_q;
								cmd.kind   = EM_REL;
								pend_d     = 1'b1;
								state_d    = S_SCAN;
							end else begin
								cmd.insert = 1'b1;
								cmd.emit   = 1'b1;
								cmd.kind   = EM_INSERT;
								pend_d     = 1'b0;
								state_d    = S_IDLE;
							end
						end
						default: begin
							if (sts.go) begin
								cmd.remove = 1'b1;
								cmd.read   = 1'b1;
								cmd.emit   = pend_q;
								cmd.kind   = EM_REL;
								pend_d     = 1'b1;
								state_d    = S_SCAN;
							end else begin
								cmd.emit = 1'b1;
								cmd.kind = EM_DONE;
								pend_d   = 1'b0;
								state_d  = S_IDLE;
							end
						end
					endcase
				end
			end
			S_HIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EM_HIT;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lhc_datapath.sv
// Datapath of the LRU handle cache: key array with parallel compare, recency
// ranks, handle memory and the result register. Depends on lhc_pkg.
`default_nettype none

module lhc_datapath import lhc_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [1:0]       opcode,
	input  wire  [63:0]      key,
	input  wire  [31:0]      handle,
	input  wire  [CAP_W-1:0] capacity,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [1:0]       status,
	output logic [31:0]      view_handle,
	output logic             released_valid,
	output logic [31:0]      released_handle,
	output logic             last
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int LW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (LW > CAP_W) ? LW + 1 : CAP_W + 1;

	logic [1:0]  op_q;
	logic [63:0] key_in_q;
	logic [31:0] handle_in_q;

	logic [63:0]   key_q   [MAX_ENTRIES];
	logic [IW-1:0] rank_q  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [LW-1:0] live_q;
	logic [31:0]   hmem    [MAX_ENTRIES];
	logic [31:0]   rd_q;

	logic [MAX_ENTRIES-1:0] sel_vec_q;
	logic [MAX_ENTRIES-1:0] free_vec_q;
	logic [IW-1:0]          sel_rank_q;
	logic                   go_q;

	logic [MAX_ENTRIES-1:0] hit_vec;
	logic [MAX_ENTRIES-1:0] lru_vec;
	logic [IW-1:0]          hit_rank;
	logic                   hit_any;
	logic                   lru_any;
	logic [CW-1:0]          live_ext;
	logic [CW-1:0]          cap_ext;
	logic [CW-1:0]          eff_cap;
	logic [MAX_ENTRIES-1:0] sel_vec_d;
	logic                   go_d;
	logic [IW-1:0]          sel_idx;
	logic [IW-1:0]          free_idx;
	logic                   free_any;
	logic                   out_free;

	function automatic logic [IW-1:0] first_one(input logic [MAX_ENTRIES-1:0] v);
		logic [IW-1:0] idx;
		idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IW'(i);
			end
		end
		return idx;
	endfunction

	// Scan: compare every live key and find the least recent entry.
	always_comb begin
		hit_rank = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key_in_q);
			lru_vec[i] = valid_q[i] && ((LW'(rank_q[i]) + 1'b1) == live_q);
			if (hit_vec[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
		end
	end

	assign hit_any  = |hit_vec;
	assign lru_any  = |lru_vec;
	assign live_ext = CW'(live_q);
	assign cap_ext  = CW'(capacity);
	assign eff_cap  = (cap_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_ext;

	always_comb begin
		case (op_q)
			OP_LOOKUP: begin
				sel_vec_d = hit_vec;
				go_d      = hit_any;
			end
			OP_INSERT: begin
				// A matching key is released before any eviction.
				sel_vec_d = hit_any ? hit_vec : lru_vec;
				go_d      = hit_any || ((live_q != '0) && (live_ext >= eff_cap) && lru_any);
			end
			OP_CLEAR: begin
				sel_vec_d = valid_q;
				go_d      = |valid_q;
			end
			default: begin
				sel_vec_d = lru_vec;
				go_d      = (live_ext > eff_cap) && lru_any;
			end
		endcase
	end

	assign sel_idx  = first_one(sel_vec_q);
	assign free_idx = first_one(free_vec_q);
	assign free_any = |free_vec_q;
	assign out_free = !out_valid || out_ready;

	assign sts.op          = op_q;
	assign sts.handle_zero = (handle_in_q == '0);
	assign sts.go          = go_q;
	assign sts.out_free    = out_free;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q        <= opcode;
			key_in_q    <= key;
			handle_in_q <= handle;
		end
		if (cmd.scan) begin
			sel_vec_q  <= sel_vec_d;
			free_vec_q <= ~valid_q;
			// A trim always removes the least recent entry, whatever its key matches.
			sel_rank_q <= (hit_any && (op_q != OP_TRIM)) ? hit_rank : IW'(live_q - 1'b1);
			go_q       <= go_d;
		end
		if (cmd.insert && free_any) begin
			key_q[free_idx] <= key_in_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && free_any) begin
			hmem[free_idx] <= handle_in_q;
		end
		if (cmd.read) begin
			rd_q <= hmem[sel_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else begin
			if (cmd.remove) begin
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (valid_q[j] && (IW'(j) != sel_idx) && (rank_q[j] > sel_rank_q)) begin
						rank_q[j] <= rank_q[j] - 1'b1;
					end
				end
				valid_q[sel_idx] <= 1'b0;
				rank_q[sel_idx]  <= '0;
				live_q           <= live_q - 1'b1;
			end
			if (cmd.touch) begin
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (valid_q[j] && (IW'(j) != sel_idx) && (rank_q[j] < sel_rank_q)) begin
						rank_q[j] <= rank_q[j] + 1'b1;
					end
				end
				rank_q[sel_idx] <= '0;
			end
			if (cmd.insert && free_any) begin
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (valid_q[j]) begin
						rank_q[j] <= rank_q[j] + 1'b1;
					end
				end
				valid_q[free_idx] <= 1'b1;
				rank_q[free_idx]  <= '0;
				live_q            <= live_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// The read register still holds the previous release when a new read is issued.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.kind)
				EM_REJECT: begin
					status          <= ST_REJECT;
					view_handle     <= '0;
					released_valid  <= 1'b0;
					released_handle <= '0;
					last            <= 1'b1;
				end
				EM_HIT: begin
					status          <= ST_OK;
					view_handle     <= rd_q;
					released_valid  <= 1'b0;
					released_handle <= '0;
					last            <= 1'b1;
				end
				EM_REL: begin
					status          <= ST_RELEASE;
					view_handle     <= '0;
					released_valid  <= 1'b1;
					released_handle <= rd_q;
					last            <= 1'b0;
				end
				EM_INSERT: begin
					status          <= ST_OK;
					view_handle     <= handle_in_q;
					released_valid  <= cmd.pend;
					released_handle <= cmd.pend ? rd_q : '0;
					last            <= 1'b1;
				end
				EM_DONE: begin
					status          <= ST_RELEASE;
					view_handle     <= '0;
					released_valid  <= cmd.pend;
					released_handle <= cmd.pend ? rd_q : '0;
					last            <= 1'b1;
				end
				default: begin
					status          <= ST_MISS;
					view_handle     <= '0;
					released_valid  <= 1'b0;
					released_handle <= '0;
					last            <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lru_handle_cache.sv
// LRU handle cache top level: each item is latched, scanned and acted on; a lookup hit
// reads its handle before its beat, and insert, clear and trim rescan after each released handle.
// Each released handle needs a scan and an action step over the entry array, and the
// handle store is a memory with a registered read port. The result register lets a new
// item be accepted while a beat waits. Reset clears the valid bits and live count and sets
// capacity to 4; key and handle stores are not cleared. Depends on lhc_pkg, lhc_ctrl, lhc_datapath.
`default_nettype none

module lru_handle_cache import lhc_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [ADDR_W-1:0] paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [1:0]        opcode,
	input  wire  [63:0]       key,
	input  wire  [31:0]       handle,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [1:0]        status,
	output logic [31:0]       view_handle,
	output logic              released_valid,
	output logic [31:0]       released_handle,
	output logic              last
);

	logic [CAP_W-1:0] cap_q;
	logic             cap_sel;
	cmd_t             cmd;
	sts_t             sts;

	assign pready  = 1'b1;
	assign cap_sel = (paddr[ADDR_W-1:2] == REG_CAPACITY);
	assign prdata  = cap_sel ? 32'(cap_q) : '0;

	// A written zero is held as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && cap_sel) begin
			cap_q <= (pwdata[CAP_W-1:0] == '0) ? CAP_W'(1) : pwdata[CAP_W-1:0];
		end
	end

	lhc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lhc_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.opcode          (opcode),
		.key             (key),
		.handle          (handle),
		.capacity        (cap_q),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.view_handle     (view_handle),
		.released_valid  (released_valid),
		.released_handle (released_handle),
		.last            (last)
	);

endmodule

`default_nettype wire
